// ===== rtl/sobel_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package sobel_pkg;

   localparam int unsigned WIDTH_BITS  = 11;
   localparam int unsigned HEIGHT_BITS = 13;
   localparam int unsigned PIXEL_BITS  = 24;
   // A sum of two squares of gradients up to 1020 needs 21 bits.
   localparam int unsigned SUM_BITS    = 21;
   localparam logic [SUM_BITS-1:0] SAT_SUM = 21'd65281;

   // Configuration register indexes.
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // Operation codes of an input word.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // capture the input word, read both line stores
      logic update;    // write line stores and shift the window
      logic compute;   // form the sums of squares
      logic root_step; // one bit of the square root
      logic finish;    // rounding and load of the output register
      logic clear;     // restart of the frame
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit;
   } status_type;

endpackage

// ===== rtl/sobel_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel controller
// Sequences a word: read, update and, for results, sums, root steps, output.
// ----------------------------------------------------------------------------
module sobel_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  csr_write,
   input  logic                  rsp_free,
   input  sobel_pkg::status_type status,
   output logic                  req_stall,
   output sobel_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_UPDATE, ST_SUMS, ST_ROOT, ST_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  step_ff, step_in;

   assign req_stall = (state_ff != ST_IDLE) | csr_write;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.clear = csr_write;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !csr_write) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.emit ? ST_SUMS : ST_IDLE;
         end
         ST_SUMS: begin
            cmd.compute = 1'b1;
            step_in     = 3'd7;
            state_in    = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff - 3'd1;
            if (step_ff == 3'd0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== rtl/sobel_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel datapath
// Line stores, window, counters, kernels and bit-serial square roots.
// ----------------------------------------------------------------------------
module sobel_dp #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sobel_pkg::cmd_type    cmd,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [12:0]           csr_data,
   input  logic                  req_operation,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_free,
   output logic [7:0]            rsp_edge_red,
   output logic [7:0]            rsp_edge_green,
   output logic [7:0]            rsp_edge_blue,
   output logic                  rsp_frame_last,
   output sobel_pkg::status_type status
);

   localparam int unsigned AW = $clog2(MAX_WIDTH);
   localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned PB = sobel_pkg::PIXEL_BITS;
   localparam int unsigned SB = sobel_pkg::SUM_BITS;
   localparam int unsigned HB = sobel_pkg::HEIGHT_BITS;
   localparam int unsigned WB = sobel_pkg::WIDTH_BITS;

   logic [WB-1:0] width_ff;
   logic [HB-1:0] height_ff;
   logic [CW-1:0] w_eff;
   logic [HB-1:0] h_eff;

   logic [PB-1:0] upper_mem [MAX_WIDTH];
   logic [PB-1:0] middle_mem [MAX_WIDTH];
   logic [PB-1:0] upper_rd_ff, middle_rd_ff, pix_ff;
   logic [CW-1:0] col_ff;
   logic [HB:0]   row_ff, out_row_ff;
   logic [CW-1:0] out_col_ff;
   logic [PB-1:0] win_ff [9];
   logic [PB-1:0] top, mid;
   logic          top_ok, mid_ok;
   logic          reload_ff, top_ok_ff, mid_ok_ff;
   logic [CW-1:0] c_now;
   logic          emit, last;

   logic [SB-1:0] sum_ff [3];
   logic [7:0]    q_ff [3];
   logic [7:0]    bit_ff;
   logic [7:0]    edge_ff [3];
   logic          last_ff, valid_ff;

   // Register values brought into range.
   always_comb begin
      if (width_ff == '0) w_eff = CW'(1);
      else if ({{(CW > WB ? CW - WB : 0){1'b0}}, width_ff} > CW'(MAX_WIDTH))
         w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(width_ff);
      h_eff = (height_ff == '0) ? HB'(1) : height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WB'(640);
         height_ff <= HB'(480);
      end else if (csr_write) begin
         if (csr_index == sobel_pkg::CSR_FRAME_WIDTH) width_ff <= csr_data[WB-1:0];
         else height_ff <= csr_data;
      end
   end

   assign c_now  = (col_ff >= w_eff) ? '0 : col_ff;
   assign top_ok = row_ff >= (HB+1)'(2) && (row_ff - (HB+1)'(2)) < {1'b0, h_eff};
   assign mid_ok = row_ff >= (HB+1)'(1) && (row_ff - (HB+1)'(1)) < {1'b0, h_eff};
   assign top = top_ok ? upper_rd_ff : '0;
   assign mid = mid_ok ? middle_rd_ff : '0;
   assign emit = (row_ff >= (HB+1)'(2)) || (row_ff == (HB+1)'(1) && c_now != '0);
   assign last = (out_row_ff == {1'b0, h_eff} - (HB+1)'(1))
                 && (out_col_ff == w_eff - CW'(1));
   assign status.emit = emit;

   // Line store reads and input capture.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         upper_rd_ff  <= upper_mem[c_now[AW-1:0]];
         middle_rd_ff <= middle_mem[c_now[AW-1:0]];
         pix_ff <= (req_operation == sobel_pkg::OP_PIXEL && row_ff < {1'b0, h_eff})
                   ? {req_red, req_green, req_blue} : '0;
      end
      if (cmd.update) begin
         upper_mem[c_now[AW-1:0]]  <= middle_rd_ff;
         middle_mem[c_now[AW-1:0]] <= pix_ff;
      end
   end

   // Window and position counters. At the first column of a row that gives a
   // result, the kernels see the window shifted by one empty column, and the
   // new column is loaded in the kernel cycle.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear || (cmd.finish && last_ff)) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (cmd.update) begin
         if (c_now == '0 && emit) begin
            win_ff[0] <= win_ff[1]; win_ff[1] <= win_ff[2]; win_ff[2] <= '0;
            win_ff[3] <= win_ff[4]; win_ff[4] <= win_ff[5]; win_ff[5] <= '0;
            win_ff[6] <= win_ff[7]; win_ff[7] <= win_ff[8]; win_ff[8] <= '0;
         end else if (c_now == '0) begin
            win_ff[0] <= '0; win_ff[1] <= '0; win_ff[2] <= top;
            win_ff[3] <= '0; win_ff[4] <= '0; win_ff[5] <= mid;
            win_ff[6] <= '0; win_ff[7] <= '0; win_ff[8] <= pix_ff;
         end else begin
            win_ff[0] <= win_ff[1]; win_ff[1] <= win_ff[2]; win_ff[2] <= top;
            win_ff[3] <= win_ff[4]; win_ff[4] <= win_ff[5]; win_ff[5] <= mid;
            win_ff[6] <= win_ff[7]; win_ff[7] <= win_ff[8]; win_ff[8] <= pix_ff;
         end
         reload_ff <= (c_now == '0) && emit;
         top_ok_ff <= top_ok;
         mid_ok_ff <= mid_ok;
         if (c_now + CW'(1) >= w_eff) begin
            col_ff <= '0;
            row_ff <= row_ff + (HB+1)'(1);
         end else begin
            col_ff <= c_now + CW'(1);
         end
         if (emit) begin
            if (out_col_ff + CW'(1) >= w_eff) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + (HB+1)'(1);
            end else begin
               out_col_ff <= out_col_ff + CW'(1);
            end
            last_ff <= last;
         end
      end else if (cmd.compute && reload_ff) begin
         win_ff[0] <= '0; win_ff[1] <= '0;
         win_ff[2] <= top_ok_ff ? upper_rd_ff : '0;
         win_ff[3] <= '0; win_ff[4] <= '0;
         win_ff[5] <= mid_ok_ff ? middle_rd_ff : '0;
         win_ff[6] <= '0; win_ff[7] <= '0;
         win_ff[8] <= pix_ff;
      end
   end

   // Kernels, sums and the bit-serial roots for the three channels.
   always_ff @(posedge clock) begin
      logic signed [11:0] gx, gy;
      logic [10:0] ax, ay;
      logic [15:0] t2;
      logic [7:0]  t;
      if (cmd.compute) begin
         for (int ch = 0; ch < 3; ch++) begin
            gx = 12'(win_ff[2][ch*8 +: 8]) + 12'(win_ff[8][ch*8 +: 8])
               + 12'({win_ff[5][ch*8 +: 8], 1'b0})
               - 12'(win_ff[0][ch*8 +: 8]) - 12'(win_ff[6][ch*8 +: 8])
               - 12'({win_ff[3][ch*8 +: 8], 1'b0});
            gy = 12'(win_ff[6][ch*8 +: 8]) + 12'(win_ff[8][ch*8 +: 8])
               + 12'({win_ff[7][ch*8 +: 8], 1'b0})
               - 12'(win_ff[0][ch*8 +: 8]) - 12'(win_ff[2][ch*8 +: 8])
               - 12'({win_ff[1][ch*8 +: 8], 1'b0});
            ax = gx[11] ? 11'(-gx) : gx[10:0];
            ay = gy[11] ? 11'(-gy) : gy[10:0];
            sum_ff[2-ch] <= SB'(22'(ax) * 22'(ax) + 22'(ay) * 22'(ay));
            q_ff[2-ch]   <= '0;
         end
         bit_ff <= 8'h80;
      end else if (cmd.root_step) begin
         for (int ch = 0; ch < 3; ch++) begin
            t  = q_ff[ch] | bit_ff;
            t2 = t * t;
            if (SB'(t2) <= sum_ff[ch]) q_ff[ch] <= t;
         end
         bit_ff <= bit_ff >> 1;
      end
   end

   // Rounding and the output register.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         for (int ch = 0; ch < 3; ch++) begin
            if (sum_ff[ch] >= sobel_pkg::SAT_SUM) edge_ff[ch] <= 8'hFF;
            else if (sum_ff[ch] > SB'(q_ff[ch] * q_ff[ch]) + SB'(q_ff[ch]))
               edge_ff[ch] <= q_ff[ch] + 8'd1;
            else edge_ff[ch] <= q_ff[ch];
         end
         rsp_frame_last <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.finish) valid_ff <= 1'b1;
      else if (!rsp_stall) valid_ff <= 1'b0;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_free       = !valid_ff || !rsp_stall;
   assign rsp_edge_red   = edge_ff[0];
   assign rsp_edge_green = edge_ff[1];
   assign rsp_edge_blue  = edge_ff[2];

endmodule

// ===== rtl/sobel_edge_magnitude_rgb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude core
// Streaming 3x3 Sobel gradient magnitude on RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Words enter on the req_ channel (valid/stall) in raster order; an operation
// of one marks a drain word. After each frame, width+1 drain words flush the
// outputs that are still pending. Results leave on the rsp_ channel, one word
// per input word once the first row plus one pixel has gone in.
// An input word that gives no result passes through a line store read and a
// window update; one that does also passes through the kernel sums, eight
// steps of the bit-serial square roots (one per channel, in parallel) and
// the rounding step.
// The output register keeps the result while the receiver stalls; the next
// word is taken in meanwhile and waits in the rounding cycle if needed.
// Reset (synchronous, active high) sets the frame to 640 x 480 and clears
// the window and the counters; the line stores need no clearing. A csr_
// write sets a register and restarts the frame.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_core #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [12:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_edge_red,
   output logic [7:0]  rsp_edge_green,
   output logic [7:0]  rsp_edge_blue,
   output logic        rsp_frame_last
);

   sobel_pkg::cmd_type    cmd;
   sobel_pkg::status_type status;
   logic                  rsp_free;

   sobel_ctrl u_ctrl (
      .clock, .reset, .req_valid, .csr_write, .rsp_free, .status,
      .req_stall, .cmd
   );

   sobel_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock, .reset, .cmd, .csr_write, .csr_index, .csr_data,
      .req_operation, .req_red, .req_green, .req_blue, .rsp_stall,
      .rsp_valid, .rsp_free, .rsp_edge_red, .rsp_edge_green, .rsp_edge_blue,
      .rsp_frame_last, .status
   );

   // A result only appears after a word was finished.
   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result without a finished word");

   // No word is taken while a configuration write is applied.
   a_no_accept_on_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |-> !cmd.accept)
      else $error("word accepted during a register write");

   // A stalled result stays valid and holds its red value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_edge_red))
      else $error("stalled result changed");

endmodule
